@@ src/frac_pkg.sv @@
// ----------------------------------------------------------------------------
// frac_pkg: shared types and constants for the fraction multiply/divide/reduce
// block. Holds the operand and product widths, the opcode codes, the
// sequencer states and the result record.
// ----------------------------------------------------------------------------
package frac_pkg;

    localparam int OPW  = 16;            // operand field width
    localparam int PW   = 2 * OPW;       // exact product width
    localparam int SW   = PW + 1;        // shared subtractor width
    localparam int CW   = $clog2(PW);    // bit counter / shift amount width
    localparam int OUTW = 32;            // result field width

    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_D,
        ST_MAG_N,
        ST_MAG_D,
        ST_GCD_TWO,
        ST_GCD_ODD,
        ST_GCD_LOOP,
        ST_GCD_END,
        ST_DIV_N,
        ST_DIV_D,
        ST_NEG_N,
        ST_NEG_D,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [OUTW-1:0] raw_num;
        logic signed [OUTW-1:0] raw_den;
        logic signed [OUTW-1:0] red_num;
        logic signed [OUTW-1:0] red_den;
        logic                   status;
    } t_result;

    // Low OUTW bits of a two's complement value, sign-extended when narrower.
    function automatic logic signed [OUTW-1:0] to_out(input logic signed [PW-1:0] v);
        return OUTW'(v);
    endfunction

endpackage

@@ src/frac_mul.sv @@
// ----------------------------------------------------------------------------
// frac_mul: signed operand multiplier
// Forms the exact signed product of two operand-width values.
// ----------------------------------------------------------------------------
module frac_mul import frac_pkg::*; (
    input  logic signed [OPW-1:0] i_a,
    input  logic signed [OPW-1:0] i_b,
    output logic signed [PW-1:0]  o_p
);

    assign o_p = i_a * i_b;

endmodule

@@ src/frac_sub.sv @@
// ----------------------------------------------------------------------------
// frac_sub: shared subtract/compare unit
// Unsigned difference of two words with a borrow flag (x < y).
// ----------------------------------------------------------------------------
module frac_sub import frac_pkg::*; (
    input  logic [SW-1:0] i_x,
    input  logic [SW-1:0] i_y,
    output logic [SW-1:0] o_diff,
    output logic          o_borrow
);

    assign {o_borrow, o_diff} = {1'b0, i_x} - {1'b0, i_y};

endmodule

@@ src/frac_core.sv @@
// ----------------------------------------------------------------------------
// frac_core: sequencer and datapath registers
// Forms the raw fraction on the multiplier, then runs magnitude, binary GCD,
// two restoring divisions and sign restore on the shared subtractor.
// ----------------------------------------------------------------------------
module frac_core import frac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_opcode,
    input  logic signed [OPW-1:0] i_num_a,
    input  logic signed [OPW-1:0] i_den_a,
    input  logic signed [OPW-1:0] i_num_b,
    input  logic signed [OPW-1:0] i_den_b,
    input  logic                  i_take,
    output logic                  o_idle,
    output logic                  o_done,
    output t_result               o_result
);

    localparam logic signed [OPW-1:0] ONE = OPW'(1);

    t_state r_state, n_state;

    logic [1:0]              r_op,  n_op;
    logic signed [OPW-1:0]   r_na,  n_na, r_da, n_da, r_nb, n_nb, r_db, n_db;
    logic signed [PW-1:0]    r_rn,  n_rn, r_rd, n_rd;
    logic [PW-1:0]           r_mn,  n_mn, r_md, n_md;
    logic [PW-1:0]           r_a,   n_a,  r_b,  n_b;
    logic [CW-1:0]           r_k,   n_k;
    logic [PW-1:0]           r_g,   n_g;
    logic [PW-1:0]           r_q,   n_q,  r_qn, n_qn, r_rem, n_rem;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic signed [OUTW-1:0]  r_red_num, n_red_num, r_red_den, n_red_den;
    logic                    r_status, n_status;

    logic signed [OPW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]    mul_p;
    logic [SW-1:0]           sub_x, sub_y, sub_diff;
    logic                    sub_borrow;

    frac_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    frac_sub u_sub (
        .i_x      (sub_x),
        .i_y      (sub_y),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_na      <= n_na;
        r_da      <= n_da;
        r_nb      <= n_nb;
        r_db      <= n_db;
        r_rn      <= n_rn;
        r_rd      <= n_rd;
        r_mn      <= n_mn;
        r_md      <= n_md;
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_g       <= n_g;
        r_q       <= n_q;
        r_qn      <= n_qn;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_red_num <= n_red_num;
        r_red_den <= n_red_den;
        r_status  <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_na      = r_na;
        n_da      = r_da;
        n_nb      = r_nb;
        n_db      = r_db;
        n_rn      = r_rn;
        n_rd      = r_rd;
        n_mn      = r_mn;
        n_md      = r_md;
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        n_g       = r_g;
        n_q       = r_q;
        n_qn      = r_qn;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_red_num = r_red_num;
        n_red_den = r_red_den;
        n_status  = r_status;
        mul_a     = r_na;
        mul_b     = ONE;
        sub_x     = '0;
        sub_y     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_na    = i_num_a;
                    n_da    = i_den_a;
                    n_nb    = i_num_b;
                    n_db    = i_den_b;
                    n_state = ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                mul_a = r_na;
                unique case (r_op)
                    OP_MUL:  mul_b = r_nb;
                    OP_DIV:  mul_b = r_db;
                    default: mul_b = ONE;
                endcase
                n_rn    = mul_p;
                n_state = ST_MUL_D;
            end
            ST_MUL_D: begin
                mul_a = r_da;
                unique case (r_op)
                    OP_MUL:  mul_b = r_db;
                    OP_DIV:  mul_b = r_nb;
                    default: mul_b = ONE;
                endcase
                n_rd    = mul_p;
                n_state = ST_MAG_N;
            end
            ST_MAG_N: begin
                sub_y   = {1'b0, r_rn};
                n_mn    = r_rn[PW-1] ? sub_diff[PW-1:0] : r_rn;
                n_a     = n_mn;
                n_state = ST_MAG_D;
            end
            ST_MAG_D: begin
                sub_y = {1'b0, r_rd};
                n_md  = r_rd[PW-1] ? sub_diff[PW-1:0] : r_rd;
                n_b   = n_md;
                n_k   = '0;
                priority if (r_rd == '0) begin
                    n_red_num = to_out(r_rn);
                    n_red_den = to_out(r_rd);
                    n_status  = 1'b1;
                    n_state   = ST_DONE;
                end else if (r_rn == '0) begin
                    n_red_num = '0;
                    n_red_den = OUTW'(1);
                    n_status  = 1'b0;
                    n_state   = ST_DONE;
                end else begin
                    n_status  = 1'b0;
                    n_state   = ST_GCD_TWO;
                end
            end
            ST_GCD_TWO: begin
                // strip common factors of two
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = ST_GCD_ODD;
                end
            end
            ST_GCD_ODD: begin
                if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else begin
                    n_state = ST_GCD_LOOP;
                end
            end
            ST_GCD_LOOP: begin
                sub_x = {1'b0, r_b};
                sub_y = {1'b0, r_a};
                priority if (r_b == '0) begin
                    n_state = ST_GCD_END;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (sub_borrow) begin
                    n_a = r_b;
                    n_b = r_a;
                end else begin
                    n_b = sub_diff[PW-1:0];
                end
            end
            ST_GCD_END: begin
                n_g     = r_a << r_k;
                n_q     = r_mn;
                n_rem   = '0;
                n_cnt   = CW'(PW - 1);
                n_state = ST_DIV_N;
            end
            ST_DIV_N, ST_DIV_D: begin
                // one restoring division step per cycle
                sub_x = {r_rem, r_q[PW-1]};
                sub_y = {1'b0, r_g};
                n_rem = sub_borrow ? sub_x[PW-1:0] : sub_diff[PW-1:0];
                n_q   = {r_q[PW-2:0], !sub_borrow};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_state == ST_DIV_N) begin
                        n_qn    = n_q;
                        n_q     = r_md;
                        n_rem   = '0;
                        n_cnt   = CW'(PW - 1);
                        n_state = ST_DIV_D;
                    end else begin
                        n_state = ST_NEG_N;
                    end
                end
            end
            ST_NEG_N: begin
                sub_y     = {1'b0, r_qn};
                n_red_num = to_out(r_rn[PW-1] ? signed'(sub_diff[PW-1:0]) : signed'(r_qn));
                n_state   = ST_NEG_D;
            end
            ST_NEG_D: begin
                sub_y     = {1'b0, r_q};
                n_red_den = to_out(r_rd[PW-1] ? signed'(sub_diff[PW-1:0]) : signed'(r_q));
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_done = (r_state == ST_DONE);

    assign o_result.raw_num = to_out(r_rn);
    assign o_result.raw_den = to_out(r_rd);
    assign o_result.red_num = r_red_num;
    assign o_result.red_den = r_red_den;
    assign o_result.status  = r_status;

endmodule

@@ src/fraction_mul_div_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_mul_div_reduce: rational multiply/divide with GCD reduction
// Passes, multiplies or divides two signed fractions and returns the raw
// result together with its lowest-terms form, signs kept per part.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  request   i_valid / o_ready     i_opcode, i_num_a, i_den_a, i_num_b, i_den_b
//  result    o_valid / i_ready     o_raw_num, o_raw_den, o_red_num, o_red_den,
//                                  o_status
//
//  Sequence: products, magnitudes, binary GCD, divider set-up, two divisions and
//  signs, then hand-off; each GCD loop step halves, subtracts or swaps, and a
//  zero part goes straight from the magnitudes to the hand-off.
//  Reset: synchronous, active low; clears the sequencer and the output valid.
//  Stalls: a finished result moves to the output register and the next request
//  is taken while it waits; the core holds its own result until the slot frees.
// ----------------------------------------------------------------------------
module fraction_mul_div_reduce import frac_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_opcode,
    input  logic signed [OPW-1:0]  i_num_a,
    input  logic signed [OPW-1:0]  i_den_a,
    input  logic signed [OPW-1:0]  i_num_b,
    input  logic signed [OPW-1:0]  i_den_b,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [OUTW-1:0] o_raw_num,
    output logic signed [OUTW-1:0] o_raw_den,
    output logic signed [OUTW-1:0] o_red_num,
    output logic signed [OUTW-1:0] o_red_den,
    output logic                   o_status
);

    logic    core_idle;
    logic    core_done;
    logic    out_free;
    logic    take;
    t_result core_res;

    logic    r_ovalid;
    t_result r_out;

    // Output slot is free when empty or being drained this cycle.
    assign out_free = !r_ovalid || i_ready;
    assign take     = core_done && out_free;
    assign o_ready  = core_idle;

    frac_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_valid && core_idle),
        .i_opcode (i_opcode),
        .i_num_a  (i_num_a),
        .i_den_a  (i_den_a),
        .i_num_b  (i_num_b),
        .i_den_b  (i_den_b),
        .i_take   (out_free),
        .o_idle   (core_idle),
        .o_done   (core_done),
        .o_result (core_res)
    );

    // Hold the result until it is taken; load a new one when the core finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_raw_num = r_out.raw_num;
    assign o_raw_den = r_out.raw_den;
    assign o_red_num = r_out.red_num;
    assign o_red_den = r_out.red_den;
    assign o_status  = r_out.status;

`ifndef SYNTHESIS
    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request port ready right after an accepted request");

    // A zero-denominator status only comes with a zero raw denominator.
    a_status_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_raw_den == '0))
        else $error("status set with nonzero raw denominator");

    // Unreduced results carry the raw fraction through.
    a_status_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_red_num == o_raw_num && o_red_den == o_raw_den))
        else $error("reduced fraction differs from raw when status set");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: fraction multiply/divide/reduce self-checking bench
// Drives opcode and fraction requests into fraction_mul_div_reduce and checks
// each result against a local rational-arithmetic predictor. A short table of
// corner cases comes first, then randomized traffic with bursty idling on
// both sides and one long result back-pressure window.
// ----------------------------------------------------------------------------
module testbench;
    import frac_pkg::*;

    // Opcode 3 is not named in the package; the block treats it as a pass.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_REQUESTS = 1650;
    localparam int IDLE_PERCENT    = 26;
    localparam int HOLD_CYCLES     = 3000;     // result back-pressure window
    localparam int HOLD_AT         = 300;      // random request that starts it
    localparam int STEADY_FIRST    = 700;      // no idling from here ...
    localparam int STEADY_LAST     = 1000;     // ... up to here
    localparam int DRAIN_CYCLES    = 300;      // longer than one full request
    localparam int CYCLE_LIMIT     = 3_000_000;

    typedef struct packed {
        logic [1:0]           op;
        logic signed [OPW-1:0] na;
        logic signed [OPW-1:0] da;
        logic signed [OPW-1:0] nb;
        logic signed [OPW-1:0] db;
    } t_fraction_req;

    typedef struct packed {
        t_fraction_req req;
        logic          typed;   // known result written into the table
        t_result       known;
    } t_fraction_row;

    typedef struct packed {
        int      tag;
        t_result want;
    } t_fraction_expect;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_opcode = OP_PASS;
    logic signed [OPW-1:0]  i_num_a = '0;
    logic signed [OPW-1:0]  i_den_a = '0;
    logic signed [OPW-1:0]  i_num_b = '0;
    logic signed [OPW-1:0]  i_den_b = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [OUTW-1:0] o_raw_num;
    logic signed [OUTW-1:0] o_raw_den;
    logic signed [OUTW-1:0] o_red_num;
    logic signed [OUTW-1:0] o_red_den;
    logic                   o_status;

    t_fraction_expect pending_results[$];
    t_fraction_row    directed_rows[$];
    t_fraction_expect result_head;

    int  error_count    = 0;
    int  sent_count     = 0;
    int  checked_count  = 0;
    int  zero_den_count = 0;
    int  zero_num_count = 0;
    int  input_stalls   = 0;
    int  op_count[4]    = '{0, 0, 0, 0};
    int  cycle_count    = 0;
    bit  steady_flow    = 1'b0;
    bit  hold_requested = 1'b0;

    fraction_mul_div_reduce i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_opcode  (i_opcode),
        .i_num_a   (i_num_a),
        .i_den_a   (i_den_a),
        .i_num_b   (i_num_b),
        .i_den_b   (i_den_b),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_raw_num (o_raw_num),
        .o_raw_den (o_raw_den),
        .o_red_num (o_red_num),
        .o_red_den (o_red_den),
        .o_status  (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Form the raw fraction exactly in 64 bits, then reduce by the GCD of the
    // magnitudes. Each part keeps its own sign; the division by the GCD is
    // exact, so a signed divide preserves it.
    function automatic t_result predict_fraction(input t_fraction_req r);
        longint                n;
        longint                d;
        longint unsigned       a;
        longint unsigned       b;
        longint unsigned       t;
        t_result               res;
        case (r.op)
            OP_MUL: begin
                n = longint'(r.na) * longint'(r.nb);
                d = longint'(r.da) * longint'(r.db);
            end
            OP_DIV: begin
                n = longint'(r.na) * longint'(r.db);
                d = longint'(r.da) * longint'(r.nb);
            end
            default: begin
                n = longint'(r.na);
                d = longint'(r.da);
            end
        endcase
        res.raw_num = n[OUTW-1:0];
        res.raw_den = d[OUTW-1:0];
        if (d == 0) begin
            // zero denominator: flag it and leave the fraction unreduced
            res.red_num = res.raw_num;
            res.red_den = res.raw_den;
            res.status  = 1'b1;
        end else if (n == 0) begin
            // zero numerator collapses to 0/1
            res.red_num = '0;
            res.red_den = 1;
            res.status  = 1'b0;
        end else begin
            a = (n < 0) ? longint'(-n) : longint'(n);
            b = (d < 0) ? longint'(-d) : longint'(d);
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            t = n / longint'(a);
            res.red_num = t[OUTW-1:0];
            t = d / longint'(a);
            res.red_den = t[OUTW-1:0];
            res.status  = 1'b0;
        end
        return res;
    endfunction

    // Append one row to the corner-case table. Rows with typed == 0 are
    // checked against the predictor; the rest carry the result written here.
    function automatic void add_row(input logic [1:0] op, input int na, input int da,
                                    input int nb, input int db, input bit typed,
                                    input int rn, input int rd, input int qn,
                                    input int qd, input bit st);
        t_fraction_row row;
        row.req.op  = op;
        row.req.na  = na[OPW-1:0];
        row.req.da  = da[OPW-1:0];
        row.req.nb  = nb[OPW-1:0];
        row.req.db  = db[OPW-1:0];
        row.typed   = typed;
        row.known.raw_num = rn;
        row.known.raw_den = rd;
        row.known.red_num = qn;
        row.known.red_den = qd;
        row.known.status  = st;
        directed_rows.push_back(row);
    endfunction

    // Mix zeros, extremes, values rich in common factors and full-range noise.
    function automatic logic signed [OPW-1:0] random_operand();
        int unsigned pick;
        int          v;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            v = 0;
        end else if (pick == 1) begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = -1;
                default: v = 1;
            endcase
        end else if (pick < 11) begin
            v = $urandom_range(1, 40) * (1 << $urandom_range(0, 6));
            if ($urandom_range(0, 1) == 1) v = -v;
        end else begin
            v = $urandom;
        end
        return v[OPW-1:0];
    endfunction

    function automatic logic [1:0] random_opcode();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick < 5) return OP_PASS;
        if (pick < 10) return OP_MUL;
        if (pick < 15) return OP_DIV;
        return OP_SPARE;
    endfunction

    task automatic flag_mismatch(input string what, input int tag,
                                 input logic signed [OUTW-1:0] got,
                                 input logic signed [OUTW-1:0] want);
        $display("mismatch: request %0d %s got %0d expected %0d",
                 tag, what, got, want);
        error_count++;
    endtask

    // Present one request and hold it until the block takes it. Idle at random
    // beforehand; a request that follows straight on keeps i_valid high.
    task automatic offer_request(input t_fraction_req r, input logic typed,
                                 input t_result known);
        t_fraction_expect e;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= r.op;
        i_num_a  <= r.na;
        i_den_a  <= r.da;
        i_num_b  <= r.nb;
        i_den_b  <= r.db;
        @(posedge i_clk);
        while (!o_ready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        // Accepted at this edge: queue what it must produce.
        e.tag  = sent_count;
        e.want = typed ? known : predict_fraction(r);
        pending_results.push_back(e);
        op_count[r.op]++;
        sent_count++;
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls, except in the steady window and during the
    // one long hold-off that lets the block fill up and block its input.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_requested) begin
                hold_requested = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge i_clk);
        end
    end

    // Compare each accepted result with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, raw_num", -1, o_raw_num, '0);
            end else begin
                result_head = pending_results.pop_front();
                if (o_raw_num !== result_head.want.raw_num)
                    flag_mismatch("raw_num", result_head.tag, o_raw_num,
                                  result_head.want.raw_num);
                if (o_raw_den !== result_head.want.raw_den)
                    flag_mismatch("raw_den", result_head.tag, o_raw_den,
                                  result_head.want.raw_den);
                if (o_red_num !== result_head.want.red_num)
                    flag_mismatch("red_num", result_head.tag, o_red_num,
                                  result_head.want.red_num);
                if (o_red_den !== result_head.want.red_den)
                    flag_mismatch("red_den", result_head.tag, o_red_den,
                                  result_head.want.red_den);
                if (o_status !== result_head.want.status)
                    flag_mismatch("status", result_head.tag, OUTW'(o_status),
                                  OUTW'(result_head.want.status));
                if (result_head.want.status)
                    zero_den_count++;
                else if (result_head.want.red_num == 0)
                    zero_num_count++;
                checked_count++;
            end
        end
    end

    // Stimulus: corner-case table, then random traffic, then drain.
    initial begin
        t_fraction_req r;
        t_result       none;

        none = '0;

        // Pass-through, including sign handling and the zero cases.
        add_row(OP_PASS, 6, 8, 0, 0, 1, 6, 8, 3, 4, 0);
        add_row(OP_PASS, 0, 5, 0, 0, 1, 0, 5, 0, 1, 0);
        add_row(OP_PASS, 7, 0, 0, 0, 1, 7, 0, 7, 0, 1);
        add_row(OP_PASS, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(OP_PASS, -32768, -32768, 0, 0, 1, -32768, -32768, -1, -1, 0);
        add_row(OP_PASS, 32767, -32768, 0, 0, 1, 32767, -32768, 32767, -32768, 0);
        add_row(OP_PASS, -1, 1, -32768, 32767, 1, -1, 1, -1, 1, 0);
        // Multiply: extreme products and the zero cases.
        add_row(OP_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, 1073741824, 1, 0);
        add_row(OP_MUL, 32767, -32768, -32768, 32767, 1,
                -1073709056, -1073709056, -1, -1, 0);
        add_row(OP_MUL, 3, 4, 0, 7, 1, 0, 28, 0, 1, 0);
        add_row(OP_MUL, 3, 0, 5, 7, 1, 15, 0, 15, 0, 1);
        add_row(OP_MUL, -1, -1, -1, -1, 1, 1, 1, 1, 1, 0);
        add_row(OP_MUL, 2, 3, 9, 4, 0, 0, 0, 0, 0, 0);
        add_row(OP_MUL, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0);
        // Divide: cross products, a zero B numerator, the extremes.
        add_row(OP_DIV, 1, 2, 0, 5, 1, 5, 0, 5, 0, 1);
        add_row(OP_DIV, 0, 3, 5, 7, 1, 0, 15, 0, 1, 0);
        add_row(OP_DIV, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(OP_DIV, -32768, 32767, 32767, -32768, 0, 0, 0, 0, 0, 0);
        add_row(OP_DIV, 6, -9, -4, 10, 0, 0, 0, 0, 0, 0);
        add_row(OP_DIV, 12, -18, -8, 6, 0, 0, 0, 0, 0, 0);
        // Unused opcode acts as pass-through; B must be ignored.
        add_row(OP_SPARE, 12, 18, -32768, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_SPARE, 0, 0, 32767, -1, 0, 0, 0, 0, 0, 0);

        // Hold reset, then release it once.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k].req, directed_rows[k].typed,
                          directed_rows[k].known);

        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k == HOLD_AT) hold_requested = 1'b1;
            steady_flow = (k >= STEADY_FIRST && k < STEADY_LAST);
            r.op = random_opcode();
            r.na = random_operand();
            r.da = random_operand();
            r.nb = random_operand();
            r.db = random_operand();
            offer_request(r, 1'b0, none);
        end
        steady_flow = 1'b0;

        // Drop the request line and wait for every outstanding result.
        @(posedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (pass %0d, mul %0d, div %0d, spare %0d), %0d checked",
                 sent_count, op_count[OP_PASS], op_count[OP_MUL], op_count[OP_DIV],
                 op_count[OP_SPARE], checked_count);
        $display("zero denominators %0d, zero numerators %0d, input stall cycles %0d",
                 zero_den_count, zero_num_count, input_stalls);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", error_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
